// ----- rtl/sci_pkg.sv -----
// shared constants for the segment against circle hit test
// no dependencies
package sci_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int SLOPE_BITS     = 32;
  localparam int OFFSET_BITS    = 32;
  localparam int SLOPE_FRAC     = 16;
  localparam int RADIUS_BITS    = 16;
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 16'd256;
  // widest multiplier digit handled by one chain cell
  localparam int DIGIT_MAX      = 9;

endpackage

// ----- rtl/sci_if.sv -----
// valid/ready channel interfaces for queries and results
// depends on sci_pkg
interface sci_query_if #(parameter int COORD_BITS = sci_pkg::COORD_BITS_DEF);
  import sci_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  start_x;
  logic signed [COORD_BITS-1:0]  start_y;
  logic signed [COORD_BITS-1:0]  end_x;
  logic signed [COORD_BITS-1:0]  end_y;
  logic signed [SLOPE_BITS-1:0]  line_slope;
  logic signed [OFFSET_BITS-1:0] line_offset;
  logic signed [COORD_BITS-1:0]  centre_x;
  logic signed [COORD_BITS-1:0]  centre_y;
  logic                          alive;

  modport source (output valid, start_x, start_y, end_x, end_y, line_slope, line_offset,
                  centre_x, centre_y, alive, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, line_slope, line_offset,
                centre_x, centre_y, alive, output ready);
endinterface

interface sci_result_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

// ----- rtl/sci_delay.sv -----
// stall-aware delay line for side data and valid bits
// no dependencies
module sci_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);
  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) line[i] <= '0;
    end else if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) line[i] <= line[i-1];
    end
  end

  assign q = line[DEPTH-1];
endmodule

// ----- rtl/sci_mul_cell.sv -----
// one cell of the digit-serial multiplier chain
// adds one shifted partial product and hands operands on
module sci_mul_cell #(
  parameter int WA  = 8,
  parameter int WBX = 8,
  parameter int D   = 8,
  parameter int P   = 17,
  parameter int IDX = 0,
  parameter bit TOP = 1'b0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [WA-1:0]  a_in,
  input  logic signed [WBX-1:0] b_in,
  input  logic signed [P-1:0]   acc_in,
  output logic signed [WA-1:0]  a_out,
  output logic signed [WBX-1:0] b_out,
  output logic signed [P-1:0]   acc_out
);
  logic [D-1:0]         digit;
  logic signed [D:0]    dig;
  logic signed [WA+D:0] pp;
  logic signed [P-1:0]  pp_ext;

  assign digit  = b_in[IDX*D +: D];
  // the top digit carries the sign of b
  assign dig    = TOP ? {digit[D-1], digit} : {1'b0, digit};
  assign pp     = a_in * dig;
  assign pp_ext = P'(pp);

  always_ff @(posedge clk) begin
    if (en) begin
      a_out   <= a_in;
      b_out   <= b_in;
      acc_out <= acc_in + (pp_ext <<< (IDX*D));
    end
  end
endmodule

// ----- rtl/sci_mul.sv -----
// signed multiplier built as a chain of registered digit cells
// depends on sci_mul_cell
module sci_mul #(
  parameter int WA = 8,
  parameter int WB = 8,
  parameter int N  = 1,
  localparam int D   = (WB + N - 1) / N,
  localparam int WBX = N * D,
  localparam int P   = WA + WBX + 1
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [WA-1:0] a,
  input  logic signed [WB-1:0] b,
  output logic signed [P-1:0]  p
);
  logic signed [WA-1:0]  a_c   [N+1];
  logic signed [WBX-1:0] b_c   [N+1];
  logic signed [P-1:0]   acc_c [N+1];

  assign a_c[0]   = a;
  assign b_c[0]   = WBX'(b);
  assign acc_c[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    sci_mul_cell #(
      .WA(WA), .WBX(WBX), .D(D), .P(P), .IDX(i), .TOP(i == N - 1)
    ) u_cell (
      .clk(clk), .en(en),
      .a_in(a_c[i]), .b_in(b_c[i]), .acc_in(acc_c[i]),
      .a_out(a_c[i+1]), .b_out(b_c[i+1]), .acc_out(acc_c[i+1])
    );
  end

  assign p = acc_c[N];
endmodule

// ----- rtl/segment_circle_intersect_test_core.sv -----
// Segment against circle hit test, one query per cycle, fully pipelined.
// A query is a segment (end points, slope, offset), a circle centre and a
// live flag; the answer says whether the segment meets the circle of the
// configured radius, decided exactly without division or square root.
// Throughput is one transfer per clock while the skid stage is empty. A
// query passes stage 1, three digit-serial multiplier chains of NA, NC
// and NE cells with stages b and d between them, and the output register.
// An output register plus a skid stage let queries keep flowing while a
// result waits. Write circle_radius only while the block is empty.
module segment_circle_intersect_test_core #(
  parameter int COORD_BITS = sci_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sci_pkg::RADIUS_BITS-1:0] cfg_wdata,
  sci_query_if.sink                       query,
  sci_result_if.source                    result
);
  import sci_pkg::*;

  // operand widths, all exact for the arithmetic that follows
  localparam int W    = COORD_BITS;
  localparam int WE   = ((OFFSET_BITS > W) ? OFFSET_BITS : W) + 1;
  localparam int WV   = W + 1;
  localparam int WCE  = SLOPE_BITS + WE;
  localparam int WP   = (((W + SLOPE_FRAC) > WCE) ? (W + SLOPE_FRAC) : WCE) + 1;
  localparam int WCC  = 2 * SLOPE_BITS;
  localparam int WK   = WCC + 1;
  localparam int WRR  = 2 * RADIUS_BITS + 1;
  localparam int WAA  = 2 * W;
  localparam int WEE  = 2 * WE;
  localparam int WQ   = ((WEE > WAA) ? WEE : WAA) + 2;
  localparam int WVV  = 2 * WV;
  localparam int WDV  = ((WVV > WRR) ? WVV : WRR) + 2;
  localparam int WPP  = 2 * WP;
  localparam int WQK  = WQ + WK;
  localparam int WDN  = ((WPP > WQK) ? WPP : WQK) + 1;
  localparam int WLK  = W + WK;
  localparam int WPU  = WP + SLOPE_FRAC;
  localparam int WT   = ((WLK > WPU) ? WLK : WPU) + 1;
  localparam int WXS  = WDN + 2 * SLOPE_FRAC;
  localparam int WTT  = 2 * WT;
  localparam int WCMP = ((WXS > WTT) ? WXS : WTT) + 1;

  // chain lengths of the three multiplier phases
  localparam int NA = (WE + DIGIT_MAX - 1) / DIGIT_MAX;
  localparam int NC = (((WP > WK) ? WP : WK) + DIGIT_MAX - 1) / DIGIT_MAX;
  localparam int NE = (WT + DIGIT_MAX - 1) / DIGIT_MAX;

  localparam int WSA = 4 + 3 * W + 2 * WV;
  localparam int WSC = 4 + WP;
  localparam int WSE = 4 + WDN + 2 * WT;

  // whole pipeline moves unless the skid stage is holding a result
  logic en;
  logic out_v, out_hit, skid_v, skid_hit;
  assign en = !skid_v;
  assign query.ready = en;

  // radius register and its square
  logic [RADIUS_BITS-1:0]   circle_radius;
  logic [2*RADIUS_BITS-1:0] rsq;
  logic signed [WRR-1:0]    rr;

  assign rsq = circle_radius * circle_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      circle_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      circle_radius <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rr <= {1'b0, rsq};
  end

  // stage 1: differences, orderings and case flags
  logic signed [W-1:0]  lo_x_c, hi_x_c, lo_y_c, hi_y_c;
  logic                 s1_v, s1_sloped, s1_point, s1_alive;
  logic signed [SLOPE_BITS-1:0] s1_c;
  logic signed [WE-1:0] s1_e;
  logic signed [W-1:0]  s1_a, s1_lo, s1_hi;
  logic signed [WV-1:0] s1_dx, s1_dy, s1_ty1, s1_ty2;

  assign lo_x_c = (query.start_x < query.end_x) ? query.start_x : query.end_x;
  assign hi_x_c = (query.start_x < query.end_x) ? query.end_x : query.start_x;
  assign lo_y_c = (query.start_y < query.end_y) ? query.start_y : query.end_y;
  assign hi_y_c = (query.start_y < query.end_y) ? query.end_y : query.start_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sloped <= query.start_x != query.end_x;
      s1_point  <= query.start_y == query.end_y;
      s1_alive  <= query.alive;
      s1_c      <= query.line_slope;
      // line offset relative to the centre row
      s1_e      <= WE'(query.line_offset) - WE'(query.centre_y);
      s1_a      <= query.centre_x;
      s1_lo     <= lo_x_c;
      s1_hi     <= hi_x_c;
      s1_dx     <= WV'(query.centre_x) - WV'(query.start_x);
      s1_dy     <= WV'(query.centre_y) - WV'(query.start_y);
      s1_ty1    <= WV'(lo_y_c) - WV'(query.centre_y);
      s1_ty2    <= WV'(query.centre_y) - WV'(hi_y_c);
    end
  end

  // phase a: squares and slope products
  logic signed [SLOPE_BITS+NA*((WE+NA-1)/NA):0]         m_ce;
  logic signed [SLOPE_BITS+NA*((SLOPE_BITS+NA-1)/NA):0] m_cc;
  logic signed [W+NA*((W+NA-1)/NA):0]                   m_aa;
  logic signed [WE+NA*((WE+NA-1)/NA):0]                 m_ee;
  logic signed [WV+NA*((WV+NA-1)/NA):0]                 m_dxx, m_dyy, m_t1v, m_t2v;

  sci_mul #(.WA(SLOPE_BITS), .WB(WE), .N(NA)) u_mul_ce (
    .clk(clk), .en(en), .a(s1_c), .b(s1_e), .p(m_ce));
  sci_mul #(.WA(SLOPE_BITS), .WB(SLOPE_BITS), .N(NA)) u_mul_cc (
    .clk(clk), .en(en), .a(s1_c), .b(s1_c), .p(m_cc));
  sci_mul #(.WA(W), .WB(W), .N(NA)) u_mul_aa (
    .clk(clk), .en(en), .a(s1_a), .b(s1_a), .p(m_aa));
  sci_mul #(.WA(WE), .WB(WE), .N(NA)) u_mul_ee (
    .clk(clk), .en(en), .a(s1_e), .b(s1_e), .p(m_ee));
  sci_mul #(.WA(WV), .WB(WV), .N(NA)) u_mul_dxx (
    .clk(clk), .en(en), .a(s1_dx), .b(s1_dx), .p(m_dxx));
  sci_mul #(.WA(WV), .WB(WV), .N(NA)) u_mul_dyy (
    .clk(clk), .en(en), .a(s1_dy), .b(s1_dy), .p(m_dyy));
  sci_mul #(.WA(WV), .WB(WV), .N(NA)) u_mul_t1v (
    .clk(clk), .en(en), .a(s1_ty1), .b(s1_ty1), .p(m_t1v));
  sci_mul #(.WA(WV), .WB(WV), .N(NA)) u_mul_t2v (
    .clk(clk), .en(en), .a(s1_ty2), .b(s1_ty2), .p(m_t2v));

  logic [WSA-1:0]       sa_q;
  logic                 sa_v, sa_sloped, sa_point, sa_alive;
  logic signed [W-1:0]  sa_a, sa_lo, sa_hi;
  logic signed [WV-1:0] sa_ty1, sa_ty2;

  sci_delay #(.WIDTH(WSA), .DEPTH(NA)) u_dly_a (
    .clk(clk), .rst(rst), .en(en),
    .d({s1_v, s1_sloped, s1_point, s1_alive, s1_a, s1_lo, s1_hi, s1_ty1, s1_ty2}),
    .q(sa_q));
  assign {sa_v, sa_sloped, sa_point, sa_alive, sa_a, sa_lo, sa_hi, sa_ty1, sa_ty2} = sa_q;

  // stage b: line coefficients, and the full vertical and point verdict
  logic signed [WDV-1:0] dxx_w, dyy_w, rr_w, dnv, t1v_w, t2v_w;
  logic                  vgt1, vgt2, vert_hit, point_hit;
  logic                  sb_v, sb_sloped, sb_alive, sb_vhit;
  logic signed [W-1:0]   sb_lo, sb_hi;
  logic signed [WP-1:0]  sb_p;
  logic signed [WK-1:0]  sb_k;
  logic signed [WQ-1:0]  sb_q;

  assign dxx_w = WDV'(WVV'(m_dxx));
  assign dyy_w = WDV'(WVV'(m_dyy));
  assign t1v_w = WDV'(WVV'(m_t1v));
  assign t2v_w = WDV'(WVV'(m_t2v));
  assign rr_w  = WDV'(rr);
  assign dnv   = rr_w - dxx_w;
  // a negative offset to the y end always passes the strict test
  assign vgt1      = sa_ty1[WV-1] || (t1v_w < dnv);
  assign vgt2      = sa_ty2[WV-1] || (t2v_w < dnv);
  assign vert_hit  = !dnv[WDV-1] && vgt1 && vgt2;
  assign point_hit = (dxx_w + dyy_w) <= rr_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_v <= 1'b0;
    end else if (en) begin
      sb_v <= sa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_sloped <= sa_sloped;
      sb_alive  <= sa_alive;
      sb_vhit   <= sa_point ? point_hit : vert_hit;
      sb_lo     <= sa_lo;
      sb_hi     <= sa_hi;
      sb_p      <= (WP'(sa_a) <<< SLOPE_FRAC) - WP'(WCE'(m_ce));
      sb_k      <= WK'(WCC'(m_cc)) + (WK'(1) <<< (2 * SLOPE_FRAC));
      sb_q      <= WQ'(WAA'(m_aa)) + WQ'(WEE'(m_ee)) - WQ'(rr);
    end
  end

  // phase c: discriminant terms and scaled x bounds
  logic signed [WP+NC*((WP+NC-1)/NC):0] m_pp;
  logic signed [WQ+NC*((WK+NC-1)/NC):0] m_qk;
  logic signed [W+NC*((WK+NC-1)/NC):0]  m_lok, m_hik;

  sci_mul #(.WA(WP), .WB(WP), .N(NC)) u_mul_pp (
    .clk(clk), .en(en), .a(sb_p), .b(sb_p), .p(m_pp));
  sci_mul #(.WA(WQ), .WB(WK), .N(NC)) u_mul_qk (
    .clk(clk), .en(en), .a(sb_q), .b(sb_k), .p(m_qk));
  sci_mul #(.WA(W), .WB(WK), .N(NC)) u_mul_lok (
    .clk(clk), .en(en), .a(sb_lo), .b(sb_k), .p(m_lok));
  sci_mul #(.WA(W), .WB(WK), .N(NC)) u_mul_hik (
    .clk(clk), .en(en), .a(sb_hi), .b(sb_k), .p(m_hik));

  logic [WSC-1:0]       sc_q;
  logic                 sc_v, sc_sloped, sc_alive, sc_vhit;
  logic signed [WP-1:0] sc_p;
  logic signed [WT-1:0] pu;

  sci_delay #(.WIDTH(WSC), .DEPTH(NC)) u_dly_c (
    .clk(clk), .rst(rst), .en(en),
    .d({sb_v, sb_sloped, sb_alive, sb_vhit, sb_p}),
    .q(sc_q));
  assign {sc_v, sc_sloped, sc_alive, sc_vhit, sc_p} = sc_q;

  assign pu = WT'(sc_p) <<< SLOPE_FRAC;

  // stage d: discriminant and distances of the root interval to the x span
  logic                  sd_v, sd_sloped, sd_alive, sd_vhit;
  logic signed [WDN-1:0] sd_dn;
  logic signed [WT-1:0]  sd_t1, sd_t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      sd_v <= 1'b0;
    end else if (en) begin
      sd_v <= sc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_sloped <= sc_sloped;
      sd_alive  <= sc_alive;
      sd_vhit   <= sc_vhit;
      sd_dn     <= WDN'(WPP'(m_pp)) - WDN'(WQK'(m_qk));
      sd_t1     <= WT'(WLK'(m_lok)) - pu;
      sd_t2     <= pu - WT'(WLK'(m_hik));
    end
  end

  // phase e: squares of the interval distances
  logic signed [WT+NE*((WT+NE-1)/NE):0] m_t1sq, m_t2sq;

  sci_mul #(.WA(WT), .WB(WT), .N(NE)) u_mul_t1sq (
    .clk(clk), .en(en), .a(sd_t1), .b(sd_t1), .p(m_t1sq));
  sci_mul #(.WA(WT), .WB(WT), .N(NE)) u_mul_t2sq (
    .clk(clk), .en(en), .a(sd_t2), .b(sd_t2), .p(m_t2sq));

  logic [WSE-1:0]         se_q;
  logic                   se_v, se_sloped, se_alive, se_vhit;
  logic signed [WDN-1:0]  se_dn;
  logic signed [WT-1:0]   se_t1, se_t2;
  logic signed [WCMP-1:0] xs;
  logic                   ge1, ge2, hit_f;

  sci_delay #(.WIDTH(WSE), .DEPTH(NE)) u_dly_e (
    .clk(clk), .rst(rst), .en(en),
    .d({sd_v, sd_sloped, sd_alive, sd_vhit, sd_dn, sd_t1, sd_t2}),
    .q(se_q));
  assign {se_v, se_sloped, se_alive, se_vhit, se_dn, se_t1, se_t2} = se_q;

  // final verdict: root interval must overlap the x span
  assign xs  = WCMP'(se_dn) <<< (2 * SLOPE_FRAC);
  assign ge1 = se_t1[WT-1] || (se_t1 == '0) || !(xs < WCMP'(WTT'(m_t1sq)));
  assign ge2 = se_t2[WT-1] || (se_t2 == '0) || !(xs < WCMP'(WTT'(m_t2sq)));
  assign hit_f = se_alive && (se_sloped ? (!se_dn[WDN-1] && ge1 && ge2) : se_vhit);

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || result.ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= se_v;
      end
    end else if (se_v && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || result.ready) begin
      out_hit <= skid_v ? skid_hit : hit_f;
    end else if (en) begin
      skid_hit <= hit_f;
    end
  end

  assign result.valid = out_v;
  assign result.hit   = out_hit;
endmodule

// ----- dv/tb_top.sv -----
// testbench for segment_circle_intersect_test_core: directed and random queries
// depends on sci_pkg, sci_query_if, sci_result_if and the core from the rtl folder
`timescale 1ns / 1ps

typedef struct {
  logic signed [15:0] sx, sy, ex, ey;
  logic signed [31:0] slope, offset;
  logic signed [15:0] cx, cy;
  logic               alive;
} seg_query_t;

typedef logic signed [255:0] wide_t;

class hit_scoreboard;
  bit        hit_q[$];
  logic [15:0] radius;
  int        errors;

  function new();
    radius = sci_pkg::RADIUS_RESET;
    errors = 0;
  endfunction

  // exact hit decision in 256-bit signed arithmetic
  function bit hit_of(seg_query_t q);
    wide_t x1, y1, x2, y2, c, d, a, b, r, rr, u, e, p, k, qq, dn, lo, hi, xs, pu, t1, t2;
    wide_t dx, dxx, dy;
    x1 = q.sx; y1 = q.sy; x2 = q.ex; y2 = q.ey;
    c = q.slope; d = q.offset; a = q.cx; b = q.cy;
    r = $signed({1'b0, radius});
    rr = r * r;
    if (!q.alive) return 0;
    if (x1 != x2) begin
      u = 65536;
      e = d - b;
      p = a * u - c * e;
      k = c * c + u * u;
      qq = a * a + e * e - rr;
      dn = p * p - qq * k;
      if (dn < 0) return 0;
      lo = (x1 < x2) ? x1 : x2;
      hi = (x1 < x2) ? x2 : x1;
      xs = dn * u * u;
      pu = p * u;
      t1 = lo * k - pu;
      t2 = pu - hi * k;
      return (t1 <= 0 || !(xs < t1 * t1)) && (t2 <= 0 || !(xs < t2 * t2));
    end
    dx = a - x1;
    dxx = dx * dx;
    if (y1 == y2) begin
      dy = b - y1;
      return !(rr < dxx + dy * dy);
    end
    dn = rr - dxx;
    if (dn < 0) return 0;
    lo = (y1 < y2) ? y1 : y2;
    hi = (y1 < y2) ? y2 : y1;
    t1 = lo - b;
    t2 = b - hi;
    return (t1 < 0 || t1 * t1 < dn) && (t2 < 0 || t2 * t2 < dn);
  endfunction

  function void note_query(seg_query_t q);
    hit_q.push_back(hit_of(q));
  endfunction

  function void check_hit(logic hit);
    bit want;
    if (hit_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual hit=%b", $time, hit);
      errors++;
      return;
    end
    want = hit_q.pop_front();
    if (hit !== want) begin
      $display("%0t: hit mismatch, expected %b, actual %b", $time, want, hit);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import sci_pkg::*;

  localparam int LATENCY_WAIT = 40;
  localparam int CYCLE_LIMIT  = 300000;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [RADIUS_BITS-1:0] cfg_wdata = '0;

  sci_query_if  query ();
  sci_result_if result ();

  segment_circle_intersect_test_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .query(query.sink), .result(result.source)
  );

  hit_scoreboard sb = new();
  int src_idle = 0;   // percent of cycles the sender holds off
  int dst_idle = 0;   // percent of cycles the receiver stalls
  int cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready) sb.check_hit(result.hit);
    result.ready <= !rst && ($urandom_range(99) >= dst_idle);
  end

  task automatic send_query(seg_query_t q);
    while ($urandom_range(99) < src_idle) begin
      query.valid <= 0;
      @(posedge clk);
    end
    query.start_x <= q.sx; query.start_y <= q.sy;
    query.end_x <= q.ex; query.end_y <= q.ey;
    query.line_slope <= q.slope; query.line_offset <= q.offset;
    query.centre_x <= q.cx; query.centre_y <= q.cy;
    query.alive <= q.alive;
    query.valid <= 1;
    @(posedge clk);
    while (!query.ready) @(posedge clk);
    sb.note_query(q);
  endtask

  // hold off until every outstanding result has come back
  task automatic drain();
    query.valid <= 0;
    @(posedge clk);
    while (sb.hit_q.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic write_radius(logic [15:0] v);
    cfg_wdata <= v;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    sb.radius = v;
  endtask

  function automatic seg_query_t make_query(int sx, int sy, int ex, int ey, longint slope,
                                             longint offset, int cx, int cy, bit alive);
    seg_query_t q;
    q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey;
    q.slope = slope; q.offset = offset;
    q.cx = cx; q.cy = cy; q.alive = alive;
    return q;
  endfunction

  function automatic int spread_rand(int s);
    return $urandom_range(2 * s) - s;
  endfunction

  // mostly segments placed near the circle with a consistent line, some pure noise
  function automatic seg_query_t random_query();
    seg_query_t q;
    int kind, s, cx, cy, x1, y1, x2, y2;
    longint slope, offset;
    kind = $urandom_range(99);
    if (kind < 12) begin
      q = make_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom_range(1));
      return q;
    end
    s = (sb.radius > 8000) ? 16000 : 2 * sb.radius + 64;
    cx = spread_rand(12000); cy = spread_rand(12000);
    x1 = cx + spread_rand(s); y1 = cy + spread_rand(s);
    x2 = cx + spread_rand(s); y2 = cy + spread_rand(s);
    if (kind < 30) x2 = x1;                       // vertical
    else if (kind < 38) begin x2 = x1; y2 = y1; end  // point
    else if (x2 == x1) x2 = x1 + 1;
    if (x2 != x1) begin
      slope = (longint'(y2 - y1) <<< 16) / (x2 - x1);
      offset = y1 - ((slope * x1) >>> 16);
    end else begin
      slope = $urandom;
      offset = $urandom;
    end
    if ($urandom_range(19) == 0) offset += spread_rand(64);  // slightly off line
    q = make_query(x1, y1, x2, y2, slope, offset, cx, cy, $urandom_range(15) != 0);
    return q;
  endfunction

  task automatic directed_queries();
    // dead circle right on the segment
    send_query(make_query(0, 0, 160, 0, 0, 0, 80, 0, 0));
    // sloped, through centre, tangent and clear miss
    send_query(make_query(-160, 0, 160, 0, 0, 0, 0, 0, 1));
    send_query(make_query(-160, 256, 160, 256, 0, 256, 0, 0, 1));
    send_query(make_query(-160, 300, 160, 300, 0, 300, 0, 0, 1));
    // sloped, roots beyond the span, span end exactly on the circle
    send_query(make_query(400, 0, 800, 0, 0, 0, 0, 0, 1));
    send_query(make_query(256, 0, 800, 0, 0, 0, 0, 0, 1));
    send_query(make_query(-32768, -32768, 32767, 32767, 65536, 0, 0, 0, 1));
    // vertical: crossing, end exactly on circle (strict), beside
    send_query(make_query(0, -500, 0, 500, 0, 0, 0, 0, 1));
    send_query(make_query(0, 256, 0, 500, 0, 0, 0, 0, 1));
    send_query(make_query(300, -500, 300, 500, 0, 0, 0, 0, 1));
    send_query(make_query(256, -500, 256, 500, 0, 0, 0, 0, 1));
    // point: inside, on the edge, outside
    send_query(make_query(10, 10, 10, 10, 0, 0, 0, 0, 1));
    send_query(make_query(256, 0, 256, 0, 0, 0, 0, 0, 1));
    send_query(make_query(257, 0, 257, 0, 0, 0, 0, 0, 1));
    // inconsistent slope and offset, extreme field values
    send_query(make_query(-100, 50, 100, 50, 32'h7fffffff, 32'h80000000, 0, 0, 1));
    send_query(make_query(-32768, 32767, 32767, -32768, 32'h80000000, 32'h7fffffff,
                          32767, -32768, 1));
    send_query(make_query(32767, 32767, 32767, 32767, 32'hffffffff, 32'hffffffff,
                          -32768, -32768, 1));
    send_query(make_query(-32768, -32768, -32768, 32767, 0, 0, -32768, 0, 1));
  endtask

  initial begin
    logic [15:0] radii[6];
    int modes[6];
    // drive every query input to a known value from time zero
    query.valid = 0;
    query.start_x = 0; query.start_y = 0; query.end_x = 0; query.end_y = 0;
    query.line_slope = 0; query.line_offset = 0;
    query.centre_x = 0; query.centre_y = 0; query.alive = 0;
    radii = '{16'd256, 16'd0, 16'hffff, 16'd1, 16'd0, 16'd0};
    radii[4] = $urandom_range(4000);
    radii[5] = $urandom_range(65535);
    // sender 28 / receiver 82, then swapped, then no idling
    modes = '{0, 0, 1, 1, 2, 2};
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int ph = 0; ph < 6; ph++) begin
      write_radius(radii[ph]);
      case (modes[ph])
        0: begin src_idle = 28; dst_idle = 82; end
        1: begin src_idle = 82; dst_idle = 28; end
        default: begin src_idle = 0; dst_idle = 0; end
      endcase
      if (ph == 0 || ph == 2) directed_queries();
      for (int i = 0; i < 230; i++) begin
        send_query(random_query());
        // stretches without idling on either side
        if (i == 150) begin src_idle = 0; dst_idle = 0; end
        if (i == 100 && ph == 1) drain();
      end
      drain();
    end
    if (sb.errors == 0 && sb.hit_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- segment_circle_intersect_test_core.f -----
rtl/sci_pkg.sv
rtl/sci_if.sv
rtl/sci_delay.sv
rtl/sci_mul_cell.sv
rtl/sci_mul.sv
rtl/segment_circle_intersect_test_core.sv
dv/tb_top.sv
